[src/ssnf_pkg.sv]
// Shared types, segment constants and digit decoder for the seven-segment number formatter.
package ssnf_pkg;

  typedef enum logic [0:0] {
    CmdInteger = 1'b0,
    CmdTenths  = 1'b1
  } cmd_e;

  typedef struct packed {
    cmd_e               cmd;
    logic signed [15:0] value;
  } in_t;

  typedef struct packed {
    logic [7:0] seg_pos1;
    logic [7:0] seg_pos2;
    logic [7:0] seg_pos3;
    logic [7:0] seg_pos4;
  } out_t;

  localparam int unsigned MagWidth = 14;

  localparam logic signed [15:0] PosLimit = 16'sd9999;
  localparam logic signed [15:0] NegLimit = -16'sd999;
  localparam logic [MagWidth-1:0] PosSatMag = 14'd9999;
  localparam logic [MagWidth-1:0] NegSatMag = 14'd999;

  localparam logic [7:0] SegBlank = 8'h00;
  localparam logic [7:0] SegMinus = 8'h40;
  localparam logic [7:0] SegPoint = 8'h80;

  // bit0 = a ... bit6 = g
  function automatic logic [7:0] digit_seg(input logic [3:0] d);
    logic [7:0] s;
    case (d)
      4'd0:    s = 8'h3F;
      4'd1:    s = 8'h06;
      4'd2:    s = 8'h5B;
      4'd3:    s = 8'h4F;
      4'd4:    s = 8'h66;
      4'd5:    s = 8'h6D;
      4'd6:    s = 8'h7D;
      4'd7:    s = 8'h07;
      4'd8:    s = 8'h7F;
      4'd9:    s = 8'h67;
      default: s = SegBlank;
    endcase
    return s;
  endfunction

endpackage

[src/ssnf_conv.sv]
// Saturation, decimal digit split and segment placement for one item.
module ssnf_conv import ssnf_pkg::*; (
  input  in_t  in_i,
  output out_t out_o
);

  logic                neg;
  logic [MagWidth-1:0] mag;
  logic [15:0]         neg_val;
  logic [26:0]         prod1;
  logic [26:0]         prod2;
  logic [27:0]         prod3;
  logic [9:0]          q1;
  logic [6:0]          q2;
  logic [3:0]          q3;
  logic [MagWidth-1:0] rem0;
  logic [9:0]          rem1;
  logic [6:0]          rem2;
  logic [3:0]          d0;
  logic [3:0]          d1;
  logic [3:0]          d2;
  logic [3:0]          d3;
  logic                ge10;
  logic                ge100;
  logic                ge1000;

  // Clamp to -999..9999 and take the magnitude.
  assign neg     = in_i.value[15];
  assign neg_val = 16'(-in_i.value);

  always_comb begin
    if (!neg) begin
      mag = (in_i.value > PosLimit) ? PosSatMag : in_i.value[MagWidth-1:0];
    end else if (in_i.value < NegLimit) begin
      mag = NegSatMag;
    end else begin
      mag = neg_val[MagWidth-1:0];
    end
  end

  // Quotients by 10, 100 and 1000 via reciprocal multiplies, exact for mag <= 9999.
  assign prod1 = {13'd0, mag} * 27'd6554;
  assign prod2 = {13'd0, mag} * 27'd5243;
  assign prod3 = {14'd0, mag} * 28'd8389;
  assign q1    = prod1[25:16];
  assign q2    = prod2[25:19];
  assign q3    = prod3[26:23];

  // Each digit is a quotient minus ten times the next one.
  assign rem0 = mag - 14'({4'd0, q1} * 14'd10);
  assign rem1 = q1 - 10'({3'd0, q2} * 10'd10);
  assign rem2 = q2 - 7'({3'd0, q3} * 7'd10);
  assign d0   = rem0[3:0];
  assign d1   = rem1[3:0];
  assign d2   = rem2[3:0];
  assign d3   = q3;

  assign ge10   = (mag > 14'd9);
  assign ge100  = (mag > 14'd99);
  assign ge1000 = (mag > 14'd999);

  always_comb begin
    out_o.seg_pos1 = ge1000 ? digit_seg(d3) : ((neg && ge100) ? SegMinus : SegBlank);
    out_o.seg_pos4 = digit_seg(d0);
    if (in_i.cmd == CmdTenths) begin
      // integer part in positions 1..3, tenths digit in position 4
      out_o.seg_pos2 = ge100 ? digit_seg(d2) : (neg ? SegMinus : SegBlank);
      out_o.seg_pos3 = digit_seg(d1) | SegPoint;
    end else begin
      out_o.seg_pos2 = ge100 ? digit_seg(d2) : ((neg && ge10) ? SegMinus : SegBlank);
      out_o.seg_pos3 = ge10 ? digit_seg(d1) : (neg ? SegMinus : SegBlank);
    end
  end

endmodule

[src/seven_segment_number_formatter_unit.sv]
// Top level: input register, converter and result register of the number formatter.
//
//   channel | signals                        | payload
//   --------+--------------------------------+---------------------------------
//   in      | in_valid_i / in_ready_o        | in_data_i  (cmd, value)
//   out     | out_valid_o / out_ready_i      | out_data_o (seg_pos1..seg_pos4)
//
// An accepted item is held in the input register, then captured in the result
// register; one item per cycle while the output is not stalled.
// The conversion sits between the input register and the result register.
// Reset empties both registers; payload registers are not reset.
// A stalled result holds the result register; the input register still fills
// and keeps accepting as soon as the result register can move.
module seven_segment_number_formatter_unit import ssnf_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic in_valid_i,
  output logic in_ready_o,
  input  in_t  in_data_i,
  output logic out_valid_o,
  input  logic out_ready_i,
  output out_t out_data_o
);

  logic in_valid_q;
  logic in_valid_d;
  in_t  in_q;
  logic out_valid_q;
  logic out_valid_d;
  out_t out_q;
  out_t conv_res;
  logic out_free;
  logic move;

  ssnf_conv u_conv (
    .in_i  (in_q),
    .out_o (conv_res)
  );

  assign out_free   = !out_valid_q || out_ready_i;
  assign move       = in_valid_q && out_free;
  assign in_ready_o = !in_valid_q || move;

  assign in_valid_d  = in_ready_o ? in_valid_i : in_valid_q;
  assign out_valid_d = out_free ? in_valid_q : out_valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      in_valid_q  <= in_valid_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      in_q <= in_data_i;
    end
    if (move) begin
      out_q <= conv_res;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  a_accept_fills: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o) |=> in_valid_q)
    else $error("accepted item not held in input register");

  a_move_fills_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    move |=> (out_valid_q && out_q == $past(conv_res)))
    else $error("converted item not captured in result register");

  a_blocked_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_q && !move) |=> (in_valid_q && $stable(in_q)))
    else $error("waiting item lost from input register");

  a_last_digit_lit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (out_data_o.seg_pos4 != SegBlank))
    else $error("rightmost position blank on a valid result");

endmodule
